// File: sv/html_entity_to_utf8_decoder_top_macros.svh
// ----------------------------------------------------------------------------
// HTML entity decoder assertion macros
// Shared property shorthands for the checker.
// ----------------------------------------------------------------------------
`ifndef HTML_ENTITY_TO_UTF8_DECODER_TOP_MACROS_SVH
`define HTML_ENTITY_TO_UTF8_DECODER_TOP_MACROS_SVH

// Same-cycle implication, reset masked
`define HED_ASSERT_NOW(lbl, clk, rst_n, lhs, rhs, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error(msg);

// Next-cycle implication, reset masked
`define HED_ASSERT_NEXT(lbl, clk, rst_n, lhs, rhs, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error(msg);

// Next-cycle implication that also holds across reset
`define HED_ASSERT_ALWAYS_NEXT(lbl, clk, lhs, rhs, msg) \
    lbl: assert property (@(posedge clk) (lhs) |=> (rhs)) else $error(msg);

`endif

// File: sv/hed_pkg.sv
// ----------------------------------------------------------------------------
// HTML entity decoder package
// Character codes, named entity tables and the burst control struct.
// ----------------------------------------------------------------------------
`default_nettype none

package hed_pkg;

    // Characters that steer the candidate scan
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_X_LO  = 8'h78;
    localparam logic [7:0] CH_X_UP  = 8'h58;

    // Code point limits
    localparam logic [23:0] CP_MAX     = 24'h10FFFF;
    localparam logic [23:0] CP_SURR_LO = 24'h00D800;
    localparam logic [23:0] CP_SURR_HI = 24'h00DFFF;

    // Body length limits (body = bytes between '&' and ';')
    localparam int DEC_MIN_LEN  = 2;
    localparam int HEX_MIN_LEN  = 3;
    localparam int NUM_MAX_LEN  = 8;
    localparam int NAME_MAX_LEN = 6;
    localparam int NAME_N       = 40;

    // Burst count width, covers windows up to 31 bytes
    localparam int CNT_W = 5;

    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        logic             run_end;
    } t_burst_ctl;

    // Names, right-justified ASCII
    localparam logic [47:0] NAME_STR [NAME_N] = '{
        "amp", "lt", "gt", "quot", "apos", "nbsp", "copy", "reg",
        "trade", "sect", "para", "deg", "plusmn", "times", "divide", "micro",
        "hellip", "mdash", "ndash", "lsquo", "rsquo", "ldquo", "rdquo", "laquo",
        "raquo", "bull", "dagger", "middot", "larr", "uarr", "rarr", "darr",
        "harr", "infin", "ne", "le", "ge", "pi", "check", "cross"
    };

    localparam int NAME_LEN [NAME_N] = '{
        3, 2, 2, 4, 4, 4, 4, 3, 5, 4, 4, 3, 6, 5, 6, 5,
        6, 5, 5, 5, 5, 5, 5, 5, 5, 4, 6, 6, 4, 4, 4, 4,
        4, 5, 2, 2, 2, 2, 5, 5
    };

    // UTF-8 expansion, first byte in the top lane
    localparam logic [23:0] NAME_UTF [NAME_N] = '{
        24'h260000, 24'h3C0000, 24'h3E0000, 24'h220000, 24'h270000, 24'hC2A000,
        24'hC2A900, 24'hC2AE00, 24'hE284A2, 24'hC2A700, 24'hC2B600, 24'hC2B000,
        24'hC2B100, 24'hC39700, 24'hC3B700, 24'hC2B500, 24'hE280A6, 24'hE28094,
        24'hE28093, 24'hE28098, 24'hE28099, 24'hE2809C, 24'hE2809D, 24'hC2AB00,
        24'hC2BB00, 24'hE280A2, 24'hE280A0, 24'hC2B700, 24'hE28690, 24'hE28691,
        24'hE28692, 24'hE28693, 24'hE28694, 24'hE2889E, 24'hE289A0, 24'hE289A4,
        24'hE289A5, 24'hCF8000, 24'hE29C93, 24'hE29C97
    };

    localparam logic [2:0] NAME_ULEN [NAME_N] = '{
        3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd2, 3'd2, 3'd2, 3'd3, 3'd2,
        3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd3, 3'd3, 3'd3, 3'd3,
        3'd3, 3'd3, 3'd3, 3'd2, 3'd2, 3'd3, 3'd3, 3'd2, 3'd3, 3'd3,
        3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd2, 3'd3, 3'd3
    };

    // Character of name t at position pos, zero past its end
    function automatic logic [7:0] name_char(input int t, input logic [2:0] pos);
        int len;
        int sh;
        begin
            len = NAME_LEN[t];
            sh  = 8 * (len - 1 - int'(pos));
            if (int'(pos) >= len) begin
                return 8'h00;
            end
            return NAME_STR[t][sh +: 8];
        end
    endfunction

endpackage

`default_nettype wire

// File: sv/hed_front.sv
// ----------------------------------------------------------------------------
// HTML entity decoder front end
// Accepts bytes, holds the entity candidate, decodes it on the fly and
// pushes one burst descriptor per byte that yields output.
// ----------------------------------------------------------------------------
`default_nettype none

module hed_front #(
    parameter int SCAN_WINDOW = 10
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [7:0]                    i_in_byte,
    input  wire logic                          i_text_end,
    input  wire logic                          i_full,
    output logic                               o_push,
    output logic [SCAN_WINDOW-1:0][7:0]        o_bytes,
    output hed_pkg::t_burst_ctl                o_ctl
);

    localparam int HOLD_D = SCAN_WINDOW - 1;
    localparam int CW     = $clog2(SCAN_WINDOW);

    // Candidate window and running decode state
    logic [7:0]              r_held [HOLD_D];
    logic [CW-1:0]           r_count, n_count;
    logic                    r_hash, n_hash;
    logic                    r_hex, n_hex;
    logic                    r_bad, n_bad;
    logic [23:0]             r_cp, n_cp;
    logic [hed_pkg::NAME_N-1:0] r_match, n_match;

    logic                    acc;
    logic                    wr_held;
    logic [CW-1:0]           wr_idx;
    logic                    do_append;
    logic [7:0]              b;
    logic [CW-1:0]           body_len;
    logic [CW-1:0]           pos;
    logic                    is_dig, is_hex;
    logic [3:0]              dig_val, hex_val;

    // Decode result
    logic                    num_ok, name_ok, dec_ok;
    logic [2:0]              dec_n;
    logic [3:0][7:0]         dec_bytes;
    logic [3:0][7:0]         num_bytes;
    logic [2:0]              num_n;
    logic [23:0]             name_utf;
    logic [2:0]              name_n;
    logic                    cp_ok;

    assign o_ready  = !i_full;
    assign acc      = i_valid && o_ready;
    assign b        = i_in_byte;
    assign body_len = r_count - CW'(1);
    assign pos      = r_count - CW'(1);

    // Digit classification
    always_comb begin
        is_dig  = (b >= 8'h30) && (b <= 8'h39);
        dig_val = b[3:0];
        is_hex  = 1'b1;
        hex_val = b[3:0];
        if (is_dig) begin
            hex_val = b[3:0];
        end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
            hex_val = b[3:0] + 4'd9;
        end else begin
            is_hex = 1'b0;
        end
    end

    // Numeric body: range check and UTF-8 encode
    always_comb begin
        cp_ok = (r_cp <= hed_pkg::CP_MAX) &&
                !((r_cp >= hed_pkg::CP_SURR_LO) && (r_cp <= hed_pkg::CP_SURR_HI));
        num_bytes = '0;
        if (r_cp < 24'h80) begin
            num_n        = 3'd1;
            num_bytes[0] = r_cp[7:0];
        end else if (r_cp < 24'h800) begin
            num_n        = 3'd2;
            num_bytes[0] = {3'b110, r_cp[10:6]};
            num_bytes[1] = {2'b10, r_cp[5:0]};
        end else if (r_cp < 24'h10000) begin
            num_n        = 3'd3;
            num_bytes[0] = {4'b1110, r_cp[15:12]};
            num_bytes[1] = {2'b10, r_cp[11:6]};
            num_bytes[2] = {2'b10, r_cp[5:0]};
        end else begin
            num_n        = 3'd4;
            num_bytes[0] = {5'b11110, r_cp[20:18]};
            num_bytes[1] = {2'b10, r_cp[17:12]};
            num_bytes[2] = {2'b10, r_cp[11:6]};
            num_bytes[3] = {2'b10, r_cp[5:0]};
        end
        if (r_hex) begin
            num_ok = (int'(body_len) >= hed_pkg::HEX_MIN_LEN) &&
                     (int'(body_len) <= hed_pkg::NUM_MAX_LEN) && !r_bad && cp_ok;
        end else begin
            num_ok = (int'(body_len) >= hed_pkg::DEC_MIN_LEN) &&
                     (int'(body_len) <= hed_pkg::NUM_MAX_LEN) && !r_bad && cp_ok;
        end
    end

    // Named body: at most one name matches both prefix and length
    always_comb begin
        name_ok  = 1'b0;
        name_utf = '0;
        name_n   = '0;
        for (int t = 0; t < hed_pkg::NAME_N; t++) begin
            if (r_match[t] && (hed_pkg::NAME_LEN[t] == int'(body_len))) begin
                name_ok  = 1'b1;
                name_utf = name_utf | hed_pkg::NAME_UTF[t];
                name_n   = name_n | hed_pkg::NAME_ULEN[t];
            end
        end
    end

    // Pick the decode outcome
    always_comb begin
        dec_ok    = 1'b0;
        dec_n     = num_n;
        dec_bytes = num_bytes;
        if (body_len != '0) begin
            if (r_hash) begin
                dec_ok = num_ok;
            end else begin
                dec_ok       = name_ok && (int'(body_len) <= hed_pkg::NAME_MAX_LEN);
                dec_n        = name_n;
                dec_bytes[0] = name_utf[23:16];
                dec_bytes[1] = name_utf[15:8];
                dec_bytes[2] = name_utf[7:0];
                dec_bytes[3] = 8'h00;
            end
        end
    end

    // Byte classification and burst build
    always_comb begin
        n_count   = r_count;
        o_push    = 1'b0;
        wr_held   = 1'b0;
        wr_idx    = r_count;
        do_append = 1'b0;
        o_ctl.cnt     = hed_pkg::CNT_W'(r_count) + hed_pkg::CNT_W'(1);
        o_ctl.run_end = i_text_end;
        // Held bytes first, the current byte right after them
        for (int k = 0; k < HOLD_D; k++) begin
            if (k < int'(r_count)) begin
                o_bytes[k] = r_held[k];
            end else begin
                o_bytes[k] = b;
            end
        end
        o_bytes[HOLD_D] = b;
        if (acc) begin
            if (r_count == '0) begin
                if (b == hed_pkg::CH_AMP && !i_text_end) begin
                    wr_held = 1'b1;
                    wr_idx  = '0;
                    n_count = CW'(1);
                end else begin
                    o_push = 1'b1;
                end
            end else if (b == hed_pkg::CH_SEMI) begin
                o_push  = 1'b1;
                n_count = '0;
                if (dec_ok) begin
                    o_ctl.cnt = hed_pkg::CNT_W'(dec_n);
                    for (int k = 0; k < 4; k++) begin
                        o_bytes[k] = dec_bytes[k];
                    end
                end
            end else if (b == hed_pkg::CH_AMP) begin
                o_push = 1'b1;
                if (i_text_end) begin
                    n_count = '0;
                end else begin
                    o_ctl.cnt = hed_pkg::CNT_W'(r_count);
                    wr_held   = 1'b1;
                    wr_idx    = '0;
                    n_count   = CW'(1);
                end
            end else if (b == hed_pkg::CH_SPACE || i_text_end ||
                         int'(r_count) == HOLD_D) begin
                o_push  = 1'b1;
                n_count = '0;
            end else begin
                wr_held   = 1'b1;
                do_append = 1'b1;
                n_count   = r_count + CW'(1);
            end
        end
    end

    // Incremental decode of the appended body byte
    always_comb begin
        n_hash  = r_hash;
        n_hex   = r_hex;
        n_bad   = r_bad;
        n_cp    = r_cp;
        n_match = r_match;
        if (do_append) begin
            for (int t = 0; t < hed_pkg::NAME_N; t++) begin
                n_match[t] = ((pos == '0) || r_match[t]) &&
                             (int'(pos) < hed_pkg::NAME_MAX_LEN) &&
                             (hed_pkg::name_char(t, pos[2:0]) == b);
            end
            if (pos == '0) begin
                n_hash = (b == hed_pkg::CH_HASH);
                n_hex  = 1'b0;
                n_bad  = 1'b0;
                n_cp   = '0;
            end else if (r_hash) begin
                if (pos == CW'(1) && (b == hed_pkg::CH_X_LO || b == hed_pkg::CH_X_UP)) begin
                    n_hex = 1'b1;
                end else if (r_hex) begin
                    if (is_hex) begin
                        n_cp = {r_cp[19:0], hex_val};
                    end else begin
                        n_bad = 1'b1;
                    end
                end else begin
                    if (is_dig) begin
                        n_cp = {r_cp[20:0], 3'b000} + {r_cp[22:0], 1'b0} + 24'(dig_val);
                    end else begin
                        n_bad = 1'b1;
                    end
                end
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Window and decode payload
    always_ff @(posedge i_clk) begin
        r_hash  <= n_hash;
        r_hex   <= n_hex;
        r_bad   <= n_bad;
        r_cp    <= n_cp;
        r_match <= n_match;
        if (wr_held) begin
            r_held[wr_idx] <= b;
        end
    end

endmodule

`default_nettype wire

// File: sv/hed_queue.sv
// ----------------------------------------------------------------------------
// HTML entity decoder burst queue
// Two-entry queue of burst descriptors between front and drain.
// ----------------------------------------------------------------------------
`default_nettype none

module hed_queue #(
    parameter int SCAN_WINDOW = 10
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_push,
    input  wire logic [SCAN_WINDOW-1:0][7:0]   i_bytes,
    input  wire hed_pkg::t_burst_ctl           i_ctl,
    output logic                               o_full,
    input  wire logic                          i_pop,
    output logic                               o_nonempty,
    output logic [SCAN_WINDOW-1:0][7:0]        o_bytes,
    output hed_pkg::t_burst_ctl                o_ctl
);

    logic [SCAN_WINDOW-1:0][7:0] r_bytes [2];
    hed_pkg::t_burst_ctl         r_ctl   [2];
    logic                        r_wr_ptr;
    logic                        r_rd_ptr;
    logic [1:0]                  r_level;

    assign o_full     = (r_level == 2'd2);
    assign o_nonempty = (r_level != 2'd0);
    assign o_bytes    = r_bytes[r_rd_ptr];
    assign o_ctl      = r_ctl[r_rd_ptr];

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_level  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_level <= r_level + 2'd1;
            end else if (i_pop && !i_push) begin
                r_level <= r_level - 2'd1;
            end
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_bytes[r_wr_ptr] <= i_bytes;
            r_ctl[r_wr_ptr]   <= i_ctl;
        end
    end

endmodule

`default_nettype wire

// File: sv/hed_drain.sv
// ----------------------------------------------------------------------------
// HTML entity decoder drain
// Walks the head burst one byte per transaction and marks its last byte.
// ----------------------------------------------------------------------------
`default_nettype none

module hed_drain #(
    parameter int SCAN_WINDOW = 10
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_nonempty,
    input  wire logic [SCAN_WINDOW-1:0][7:0]   i_bytes,
    input  wire hed_pkg::t_burst_ctl           i_ctl,
    output logic                               o_pop,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [7:0]                         o_out_byte,
    output logic                               o_burst_last,
    output logic                               o_run_end
);

    localparam int IW = $clog2(SCAN_WINDOW);

    logic [IW-1:0] r_idx, n_idx;
    logic          last;

    assign last         = (hed_pkg::CNT_W'(r_idx) + hed_pkg::CNT_W'(1)) == i_ctl.cnt;
    assign o_valid      = i_nonempty;
    assign o_out_byte   = i_bytes[r_idx];
    assign o_burst_last = last;
    assign o_run_end    = last && i_ctl.run_end;
    assign o_pop        = o_valid && i_ready && last;

    // Byte index within the head burst
    always_comb begin
        n_idx = r_idx;
        if (o_valid && i_ready) begin
            n_idx = last ? '0 : r_idx + IW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else begin
            r_idx <= n_idx;
        end
    end

endmodule

`default_nettype wire

// File: sv/html_entity_to_utf8_decoder_top.sv
// ----------------------------------------------------------------------------
// HTML entity to UTF-8 decoder
// Streams text bytes, replaces well-formed entities by UTF-8, passes the rest.
// ----------------------------------------------------------------------------
//  channel   direction  handshake           payload
//  input     in         i_valid / o_ready   i_in_byte, i_text_end
//  output    out        o_valid / i_ready   o_out_byte, o_burst_last, o_run_end
//
//  One input byte is taken per cycle while the burst queue has room.
//  The drain sends one result byte per output transaction, so sustained
//  input rate follows the output burst size. The first result byte of a
//  burst is registered in the burst queue before it shows at the output.
//  Synchronous active-low reset clears the window count, queue and drain.
//  Either side may stall; the two-entry queue decouples them.
// ----------------------------------------------------------------------------
`default_nettype none

module html_entity_to_utf8_decoder_top #(
    parameter int SCAN_WINDOW = 10
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_text_end,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [7:0]      o_out_byte,
    output logic            o_burst_last,
    output logic            o_run_end
);

    logic                        full;
    logic                        push;
    logic                        pop;
    logic                        nonempty;
    logic [SCAN_WINDOW-1:0][7:0] f_bytes;
    logic [SCAN_WINDOW-1:0][7:0] q_bytes;
    hed_pkg::t_burst_ctl         f_ctl;
    hed_pkg::t_burst_ctl         q_ctl;

    hed_front #(.SCAN_WINDOW(SCAN_WINDOW)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_in_byte  (i_in_byte),
        .i_text_end (i_text_end),
        .i_full     (full),
        .o_push     (push),
        .o_bytes    (f_bytes),
        .o_ctl      (f_ctl)
    );

    hed_queue #(.SCAN_WINDOW(SCAN_WINDOW)) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_bytes    (f_bytes),
        .i_ctl      (f_ctl),
        .o_full     (full),
        .i_pop      (pop),
        .o_nonempty (nonempty),
        .o_bytes    (q_bytes),
        .o_ctl      (q_ctl)
    );

    hed_drain #(.SCAN_WINDOW(SCAN_WINDOW)) u_drain (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_nonempty   (nonempty),
        .i_bytes      (q_bytes),
        .i_ctl        (q_ctl),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_out_byte   (o_out_byte),
        .o_burst_last (o_burst_last),
        .o_run_end    (o_run_end)
    );

endmodule

`default_nettype wire

// File: sv/hed_checker.sv
// ----------------------------------------------------------------------------
// HTML entity decoder port checker
// Watches the top-level ports and flags handshake and framing slips.
// ----------------------------------------------------------------------------
`default_nettype none

`include "html_entity_to_utf8_decoder_top_macros.svh"

module hed_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_valid,
    input wire logic       o_ready,
    input wire logic [7:0] i_in_byte,
    input wire logic       i_text_end,
    input wire logic       o_valid,
    input wire logic       i_ready,
    input wire logic [7:0] o_out_byte,
    input wire logic       o_burst_last,
    input wire logic       o_run_end
);

    // Stalled output transaction keeps valid and its byte
    `HED_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_out_byte), "output dropped while stalled")

    // Stalled input transaction keeps valid and its payload
    `HED_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, i_valid && !o_ready, i_valid && $stable(i_in_byte) && $stable(i_text_end), "input changed while stalled")

    // Run end only closes a burst
    `HED_ASSERT_NOW(a_run_end_last, i_clk, i_rst_n, o_valid && o_run_end, o_burst_last, "run end not on burst last byte")

    // Reset empties the output side
    `HED_ASSERT_ALWAYS_NEXT(a_reset_empty, i_clk, !i_rst_n, !o_valid, "output valid after reset")

    // A text-end byte always produces output next cycle
    `HED_ASSERT_NEXT(a_end_yields, i_clk, i_rst_n, i_valid && o_ready && i_text_end, o_valid, "no output for text end")

endmodule

bind html_entity_to_utf8_decoder_top hed_checker u_hed_checker (.*);

`default_nettype wire

// File: test/tb_html_entity_to_utf8_decoder_top.sv
// ----------------------------------------------------------------------------
// HTML entity decoder testbench
// Drives byte runs with entities, broken candidates and noise through the
// decoder, predicts each output byte and compares every output transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_html_entity_to_utf8_decoder_top;

    localparam int WIN        = 10;
    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic [7:0] byte_val;
        logic       text_end;
    } t_text_txn;

    typedef struct packed {
        logic [7:0] byte_val;
        logic       burst_last;
        logic       run_end;
    } t_utf_txn;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    logic [7:0] i_in_byte;
    logic       i_text_end;
    logic       o_valid;
    logic       i_ready;
    logic [7:0] o_out_byte;
    logic       o_burst_last;
    logic       o_run_end;

    html_entity_to_utf8_decoder_top #(.SCAN_WINDOW(WIN)) u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_in_byte(i_in_byte), .i_text_end(i_text_end), .o_valid(o_valid),
        .i_ready(i_ready), .o_out_byte(o_out_byte), .o_burst_last(o_burst_last),
        .o_run_end(o_run_end)
    );

    t_text_txn  text_q[$];
    t_utf_txn   utf_q[$];
    logic [7:0] cand_bytes[WIN-1];
    int         cand_cnt;
    int         err_cnt;
    int         in_cnt;
    int         out_cnt;
    int         idle_cycles;
    int         hold_off;
    bit         no_gaps;
    bit         drain_hold;
    int         send_gap;
    int         recv_gap;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    task automatic report(input string what, input int got, input int want);
        err_cnt++;
        $display("MISMATCH out #%0d %s: got %02h want %02h", out_cnt, what, got, want);
    endtask

    // Predictor: UTF-8 encode of a code point, empty on invalid
    function automatic int encode_utf8(input logic [31:0] cp, output logic [7:0] ub[4]);
        if (cp > 32'h10FFFF || (cp >= 32'hD800 && cp <= 32'hDFFF)) return 0;
        if (cp < 32'h80) begin
            ub[0] = cp[7:0];
            return 1;
        end
        if (cp < 32'h800) begin
            ub[0] = 8'hC0 | cp[10:6];
            ub[1] = 8'h80 | cp[5:0];
            return 2;
        end
        if (cp < 32'h10000) begin
            ub[0] = 8'hE0 | cp[15:12];
            ub[1] = 8'h80 | cp[11:6];
            ub[2] = 8'h80 | cp[5:0];
            return 3;
        end
        ub[0] = 8'hF0 | cp[20:18];
        ub[1] = 8'h80 | cp[17:12];
        ub[2] = 8'h80 | cp[11:6];
        ub[3] = 8'h80 | cp[5:0];
        return 4;
    endfunction

    // Predictor: decode held body (cand_bytes[1..cand_cnt-1]); 0 on failure
    function automatic int decode_entity(output logic [7:0] ub[4]);
        int         len;
        logic [31:0] cp;
        logic [7:0] c;
        bit         hit;
        len = cand_cnt - 1;
        cp  = 0;
        if (len == 0) return 0;
        if (cand_bytes[1] == hed_pkg::CH_HASH) begin
            if (len < 2) return 0;
            if (cand_bytes[2] == hed_pkg::CH_X_LO || cand_bytes[2] == hed_pkg::CH_X_UP) begin
                if (len < 3 || len > 8) return 0;
                for (int k = 3; k <= len; k++) begin
                    c  = cand_bytes[k];
                    cp = cp << 4;
                    if (c >= "0" && c <= "9") cp |= c - "0";
                    else if (c >= "a" && c <= "f") cp |= c - "a" + 10;
                    else if (c >= "A" && c <= "F") cp |= c - "A" + 10;
                    else return 0;
                end
            end else begin
                if (len > 8) return 0;
                for (int k = 2; k <= len; k++) begin
                    c = cand_bytes[k];
                    if (c < "0" || c > "9") return 0;
                    cp = cp * 10 + (c - "0");
                end
            end
            return encode_utf8(cp, ub);
        end
        if (len > hed_pkg::NAME_MAX_LEN) return 0;
        for (int t = 0; t < hed_pkg::NAME_N; t++) begin
            if (hed_pkg::NAME_LEN[t] != len) continue;
            hit = 1'b1;
            for (int k = 0; k < len; k++)
                if (hed_pkg::NAME_STR[t][8*(len-1-k) +: 8] != cand_bytes[k+1]) hit = 1'b0;
            if (hit) begin
                for (int k = 0; k < 3; k++) ub[k] = hed_pkg::NAME_UTF[t][8*(2-k) +: 8];
                return hed_pkg::NAME_ULEN[t];
            end
        end
        return 0;
    endfunction

    // Predictor: one input byte to its burst of expected output bytes
    function automatic void predict_text(input t_text_txn tx);
        logic [7:0] burst[$];
        logic [7:0] ub[4];
        logic [7:0] b;
        int         n;
        b = tx.byte_val;
        if (cand_cnt == 0) begin
            if (b == hed_pkg::CH_AMP && !tx.text_end) begin
                cand_bytes[0] = b;
                cand_cnt = 1;
            end else burst.insert(burst.size(), b);
        end else if (b == hed_pkg::CH_SEMI) begin
            n = decode_entity(ub);
            if (n > 0) for (int k = 0; k < n; k++) burst.insert(burst.size(), ub[k]);
            else begin
                for (int k = 0; k < cand_cnt; k++) burst.insert(burst.size(), cand_bytes[k]);
                burst.insert(burst.size(), b);
            end
            cand_cnt = 0;
        end else if (b == hed_pkg::CH_AMP) begin
            for (int k = 0; k < cand_cnt; k++) burst.insert(burst.size(), cand_bytes[k]);
            if (tx.text_end) begin
                burst.insert(burst.size(), b);
                cand_cnt = 0;
            end else begin
                cand_bytes[0] = b;
                cand_cnt = 1;
            end
        end else if (b == hed_pkg::CH_SPACE || tx.text_end || cand_cnt + 1 >= WIN) begin
            for (int k = 0; k < cand_cnt; k++) burst.insert(burst.size(), cand_bytes[k]);
            burst.insert(burst.size(), b);
            cand_cnt = 0;
        end else begin
            cand_bytes[cand_cnt] = b;
            cand_cnt++;
        end
        foreach (burst[k])
            utf_q.insert(utf_q.size(), '{burst[k], k == burst.size() - 1,
                                          (k == burst.size() - 1) && tx.text_end});
    endfunction

    function automatic void push_str(input string s, input bit end_last);
        for (int k = 0; k < s.len(); k++)
            text_q.insert(text_q.size(), '{s[k], end_last && k == s.len() - 1});
    endfunction

    function automatic string rand_entity();
        string s;
        int    sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0, 1, 2: begin
                s = "&";
                sel = $urandom_range(0, hed_pkg::NAME_N - 1);
                for (int k = 0; k < hed_pkg::NAME_LEN[sel]; k++)
                    s = {s, string'(hed_pkg::NAME_STR[sel][8*(hed_pkg::NAME_LEN[sel]-1-k) +: 8])};
                if ($urandom_range(0, 4) == 0) s[1] = s[1] ^ 8'h20;
                s = {s, ";"};
            end
            3, 4: s = $sformatf("&#%0d;", $urandom_range(0, 1200000));
            5:    s = $sformatf("&#%0d;", $urandom_range(55290, 57400));
            6, 7: s = $sformatf($urandom_range(0, 1) ? "&#x%0h;" : "&#X%0H;",
                                $urandom_range(0, 24'h11FFFF));
            8:    s = $sformatf("&#x%0h;", $urandom_range(24'hD7F0, 24'hE010));
            default: begin
                s = "&";
                for (int k = $urandom_range(0, 10); k > 0; k--)
                    s = {s, string'(8'($urandom_range(0, 255)))};
            end
        endcase
        return s;
    endfunction

    // Driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid    <= 1'b0;
            i_in_byte  <= 8'h00;
            i_text_end <= 1'b0;
            send_gap   <= 0;
        end else if (!i_valid || o_ready) begin
            if (i_valid) begin
                predict_text('{i_in_byte, i_text_end});
                in_cnt++;
            end
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                i_valid  <= 1'b0;
            end else if (text_q.size() > 0 && !(drain_hold && utf_q.size() > 0)) begin
                i_valid    <= 1'b1;
                i_in_byte  <= text_q[0].byte_val;
                i_text_end <= text_q[0].text_end;
                void'(text_q.pop_front());
                if (!no_gaps && $urandom_range(0, 5) == 0)
                    send_gap <= $urandom_range(1, 11);
            end else i_valid <= 1'b0;
        end
    end

    // Monitor and output stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready  <= 1'b0;
            recv_gap <= 0;
        end else begin
            if (o_valid && i_ready) begin
                if (utf_q.size() == 0) begin
                    err_cnt++;
                    $display("UNEXPECTED output byte %02h", o_out_byte);
                end else begin
                    if (o_out_byte != utf_q[0].byte_val)
                        report("byte", o_out_byte, utf_q[0].byte_val);
                    if (o_burst_last != utf_q[0].burst_last)
                        report("burst_last", o_burst_last, utf_q[0].burst_last);
                    if (o_run_end != utf_q[0].run_end)
                        report("run_end", o_run_end, utf_q[0].run_end);
                    void'(utf_q.pop_front());
                end
                out_cnt++;
            end
            if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                i_ready  <= 1'b0;
            end else begin
                i_ready <= 1'b1;
                if (!no_gaps && $urandom_range(0, 5) == 0)
                    recv_gap <= $urandom_range(1, 11);
            end
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout with %0d output bytes outstanding", utf_q.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        string s;
        int    base;
        err_cnt = 0; in_cnt = 0; out_cnt = 0; idle_cycles = 0;
        cand_cnt = 0; no_gaps = 1'b0; drain_hold = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0; i_in_byte = 8'h00; i_text_end = 1'b0; i_ready = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes, each failure kind, text end cases
        push_str("&amp;&#0;&#x10FFFF;&#1114112;&#xD800;&#;&# ;&&lt;", 1'b0);
        push_str("&cross;&#X41;&#xFFFF;&Amp;&abcdefghi", 1'b0);
        text_q.insert(text_q.size(), '{8'hFF, 1'b0});
        text_q.insert(text_q.size(), '{8'h00, 1'b0});
        push_str("&ab&", 1'b1);
        push_str("&", 1'b1);
        push_str("x&q", 1'b1);
        wait (text_q.size() == 0 && !i_valid && utf_q.size() == 0);

        // Sender holds until all results are drained
        drain_hold = 1'b1;
        push_str("&#128512;&#2047;", 1'b0);
        wait (text_q.size() == 0 && !i_valid && utf_q.size() == 0);
        drain_hold = 1'b0;

        // Random runs: mostly entities, some noise and broken candidates
        base = in_cnt;
        while (in_cnt + text_q.size() < base + 200) begin
            if (text_q.size() < 20) begin
                if ($urandom_range(0, 3) == 0)
                    text_q.insert(text_q.size(), '{8'($urandom_range(0, 255)),
                                                   1'($urandom_range(0, 9) == 0)});
                else begin
                    s = rand_entity();
                    push_str(s, $urandom_range(0, 7) == 0);
                end
                if (in_cnt + text_q.size() > base + 170) no_gaps = 1'b1;
            end else @(posedge i_clk);
        end
        text_q.insert(text_q.size(), '{8'h2E, 1'b1});
        wait (text_q.size() == 0 && !i_valid && utf_q.size() == 0);
        repeat (20) @(posedge i_clk);

        $display("Sent %0d text bytes, checked %0d output bytes", in_cnt, out_cnt);
        $display("Covered named, decimal, hex, invalid, space, ampersand and end cases");
        if (err_cnt == 0 && utf_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+sv
sv/hed_pkg.sv
sv/hed_front.sv
sv/hed_queue.sv
sv/hed_drain.sv
sv/html_entity_to_utf8_decoder_top.sv
sv/hed_checker.sv
test/tb_html_entity_to_utf8_decoder_top.sv
